// File: design/spsq_pkg.sv
package spsq_pkg;

   localparam int FUNC_W  = 2;
   localparam int KEY_W   = 16;
   localparam int ID_W    = 32;
   localparam int COUNT_W = 5;

   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_STATUS = 2'd3;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   // Command broadcast to every cell of the chain at once.
   typedef struct packed {
      logic             insert;
      logic             remove;
      logic [KEY_W-1:0] new_key;
      logic [ID_W-1:0]  new_id;
   } cell_cmd_type;

endpackage

// File: design/spsq_if.sv
interface spsq_req_if;
   import spsq_pkg::*;

   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [KEY_W-1:0]  key;
   logic [ID_W-1:0]   item_id;

   modport source (output valid, output func, output key, output item_id, input ready);
   modport sink   (input valid, input func, input key, input item_id, output ready);
endinterface

interface spsq_rsp_if;
   import spsq_pkg::*;

   logic               valid;
   logic               ready;
   logic               status;
   logic [KEY_W-1:0]   out_key;
   logic [ID_W-1:0]    out_id;
   logic [KEY_W-1:0]   head_key;
   logic [ID_W-1:0]    head_id;
   logic [KEY_W-1:0]   tail_key;
   logic [ID_W-1:0]    tail_id;
   logic [COUNT_W-1:0] entry_count;
   logic               is_empty;

   modport source (output valid, output status, output out_key, output out_id,
                   output head_key, output head_id, output tail_key, output tail_id,
                   output entry_count, output is_empty, input ready);
   modport sink   (input valid, input status, input out_key, input out_id,
                   input head_key, input head_id, input tail_key, input tail_id,
                   input entry_count, input is_empty, output ready);
endinterface

// File: design/spsq_cell.sv
module spsq_cell (
   input  logic                       clock,
   input  spsq_pkg::cell_cmd_type     cmd,
   input  logic                       occupied,
   input  logic                       left_take,
   input  logic [spsq_pkg::KEY_W-1:0] left_key,
   input  logic [spsq_pkg::ID_W-1:0]  left_id,
   input  logic [spsq_pkg::KEY_W-1:0] right_key,
   input  logic [spsq_pkg::ID_W-1:0]  right_id,
   output logic                       take,
   output logic [spsq_pkg::KEY_W-1:0] key_out,
   output logic [spsq_pkg::ID_W-1:0]  id_out
);
   import spsq_pkg::*;

   logic [KEY_W-1:0] key_ff, key_in;
   logic [ID_W-1:0]  id_ff, id_in;

   // A new entry lands in front of the first stored key that is strictly
   // smaller, so it goes behind every equal key already queued.
   assign take = !occupied || (key_ff < cmd.new_key);

   always_comb begin
      key_in = key_ff;
      id_in  = id_ff;
      priority if (cmd.insert && left_take) begin
         key_in = left_key;
         id_in  = left_id;
      end else if (cmd.insert && take) begin
         key_in = cmd.new_key;
         id_in  = cmd.new_id;
      end else if (cmd.remove) begin
         key_in = right_key;
         id_in  = right_id;
      end else begin
         key_in = key_ff;
         id_in  = id_ff;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      id_ff  <= id_in;
   end

   assign key_out = key_ff;
   assign id_out  = id_ff;

endmodule

// File: design/stable_sorted_priority_queue.sv
// Stable sorted priority queue built as a shift chain of CAPACITY cells.
// An accepted request passes through a pending stage into the result registers,
// formed from the cell contents in the cycle after they update, tail included;
// no new request is accepted while one is pending or a result awaits ready.
// Reset: synchronous, active high; empties the queue and drops any result.
module stable_sorted_priority_queue #(
   parameter int CAPACITY = 16
) (
   input  logic       clock,
   input  logic       reset,
   spsq_req_if.sink   req_chan,
   spsq_rsp_if.source rsp_chan
);
   import spsq_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             pending_ff;
   logic             status_ff, status_in;
   logic [KEY_W-1:0] rem_key_ff, rem_key_in;
   logic [ID_W-1:0]  rem_id_ff, rem_id_in;

   logic               rsp_valid_ff;
   logic               rsp_status_ff;
   logic [KEY_W-1:0]   rsp_out_key_ff, rsp_head_key_ff, rsp_tail_key_ff;
   logic [ID_W-1:0]    rsp_out_id_ff, rsp_head_id_ff, rsp_tail_id_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic               rsp_empty_ff;

   logic [KEY_W-1:0] cell_key [CAPACITY];
   logic [ID_W-1:0]  cell_id  [CAPACITY];
   logic [CAPACITY-1:0] cell_take;
   logic [CAPACITY-1:0] cell_occ;

   cell_cmd_type cmd;
   logic accept, full, empty, do_ins, do_rem;
   logic [CNT_W-1:0] count_m1;
   logic [IDX_W-1:0] tail_idx;
   logic [CNT_W+COUNT_W-1:0] count_wide;

   assign full   = (count_ff == CNT_W'(CAPACITY));
   assign empty  = (count_ff == '0);
   assign req_chan.ready = !reset && !pending_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign accept = req_chan.valid && req_chan.ready;
   assign do_ins = accept && (req_chan.func == FUNC_INSERT) && !full;
   assign do_rem = accept && (req_chan.func == FUNC_REMOVE) && !empty;

   assign cmd.insert  = do_ins;
   assign cmd.remove  = do_rem;
   assign cmd.new_key = req_chan.key;
   assign cmd.new_id  = req_chan.item_id;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign cell_occ[i] = (CNT_W'(i) < count_ff);

      if (i == 0) begin : g_first
         spsq_cell u_cell (
            .clock     (clock),
            .cmd       (cmd),
            .occupied  (cell_occ[i]),
            .left_take (1'b0),
            .left_key  ('0),
            .left_id   ('0),
            .right_key (cell_key[(i + 1) % CAPACITY]),
            .right_id  (cell_id[(i + 1) % CAPACITY]),
            .take      (cell_take[i]),
            .key_out   (cell_key[i]),
            .id_out    (cell_id[i])
         );
      end else if (i == CAPACITY - 1) begin : g_last
         spsq_cell u_cell (
            .clock     (clock),
            .cmd       (cmd),
            .occupied  (cell_occ[i]),
            .left_take (cell_take[i-1]),
            .left_key  (cell_key[i-1]),
            .left_id   (cell_id[i-1]),
            .right_key (cell_key[i]),
            .right_id  (cell_id[i]),
            .take      (cell_take[i]),
            .key_out   (cell_key[i]),
            .id_out    (cell_id[i])
         );
      end else begin : g_mid
         spsq_cell u_cell (
            .clock     (clock),
            .cmd       (cmd),
            .occupied  (cell_occ[i]),
            .left_take (cell_take[i-1]),
            .left_key  (cell_key[i-1]),
            .left_id   (cell_id[i-1]),
            .right_key (cell_key[i+1]),
            .right_id  (cell_id[i+1]),
            .take      (cell_take[i]),
            .key_out   (cell_key[i]),
            .id_out    (cell_id[i])
         );
      end
   end

   always_comb begin
      count_in = count_ff;
      priority if (do_ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_rem) begin
         count_in = count_ff - CNT_W'(1);
      end else if (accept && (req_chan.func == FUNC_CLEAR)) begin
         count_in = '0;
      end else begin
         count_in = count_ff;
      end
   end

   always_comb begin
      status_in  = STATUS_OK;
      rem_key_in = '0;
      rem_id_in  = '0;
      unique case (req_chan.func)
         FUNC_INSERT: begin
            if (full) status_in = STATUS_FAIL;
         end
         FUNC_REMOVE: begin
            if (empty) begin
               status_in = STATUS_FAIL;
            end else begin
               rem_key_in = cell_key[0];
               rem_id_in  = cell_id[0];
            end
         end
         FUNC_CLEAR, FUNC_STATUS: begin
            status_in = STATUS_OK;
         end
         default: begin
            status_in = STATUS_OK;
         end
      endcase
   end

   assign count_m1   = count_ff - CNT_W'(1);
   assign tail_idx   = count_m1[IDX_W-1:0];
   assign count_wide = {{COUNT_W{1'b0}}, count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         pending_ff <= accept;
         if (pending_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff  <= status_in;
         rem_key_ff <= rem_key_in;
         rem_id_ff  <= rem_id_in;
      end
      // The cells have settled by now, so head and tail reflect the operation.
      if (pending_ff) begin
         rsp_status_ff  <= status_ff;
         rsp_out_key_ff <= rem_key_ff;
         rsp_out_id_ff  <= rem_id_ff;
         rsp_count_ff   <= count_wide[COUNT_W-1:0];
         rsp_empty_ff   <= empty;
         if (empty) begin
            rsp_head_key_ff <= '0;
            rsp_head_id_ff  <= '0;
            rsp_tail_key_ff <= '0;
            rsp_tail_id_ff  <= '0;
         end else begin
            rsp_head_key_ff <= cell_key[0];
            rsp_head_id_ff  <= cell_id[0];
            rsp_tail_key_ff <= cell_key[tail_idx];
            rsp_tail_id_ff  <= cell_id[tail_idx];
         end
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.out_key     = rsp_out_key_ff;
   assign rsp_chan.out_id      = rsp_out_id_ff;
   assign rsp_chan.head_key    = rsp_head_key_ff;
   assign rsp_chan.head_id     = rsp_head_id_ff;
   assign rsp_chan.tail_key    = rsp_tail_key_ff;
   assign rsp_chan.tail_id     = rsp_tail_id_ff;
   assign rsp_chan.entry_count = rsp_count_ff;
   assign rsp_chan.is_empty    = rsp_empty_ff;

endmodule
